// ----- src/fpdt_pkg.sv -----
`default_nettype none

package fpdt_pkg;

  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINIMAL_DIGITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_DIGITS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_FRAC_BITS       = 6'd12;
  localparam logic                  RESET_MINIMAL_DIGITS  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] RESET_FRACTION_DIGITS = 6'd0;
  localparam logic [CFG_DATA_W-1:0] DIGIT_LIMIT           = 6'd32;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] frac_bits;
    logic                  minimal_digits;
    logic [CFG_DATA_W-1:0] fraction_digits;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic split;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_int;
    logic emit_point;
    logic emit_frac;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic dabble_done;
    logic lead_zero;
    logic int_final;
    logic point;
    logic frac_final;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/fpdt_channels.sv -----
`default_nettype none

interface fpdt_in_if
  import fpdt_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface fpdt_out_if
  import fpdt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  modport source(output valid, output character, output last, input ready);
  modport sink(input valid, input character, input last, output ready);
endinterface

interface fpdt_cfg_if
  import fpdt_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/fpdt_cfg_regs.sv -----
`default_nettype none

module fpdt_cfg_regs
  import fpdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  fpdt_cfg_if.sink        cfg_ch,
  output cfg_t            cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAC_BITS:       cfg_nxt.frac_bits = cfg_ch.data;
        REG_MINIMAL_DIGITS:  cfg_nxt.minimal_digits = cfg_ch.data[0];
        REG_FRACTION_DIGITS: cfg_nxt.fraction_digits = cfg_ch.data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frac_bits       <= RESET_FRAC_BITS;
      cfg_r.minimal_digits  <= RESET_MINIMAL_DIGITS;
      cfg_r.fraction_digits <= RESET_FRACTION_DIGITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/fpdt_dp.sv -----
`default_nettype none

module fpdt_dp
  import fpdt_pkg::*;
#(
  parameter int VALUE_BITS    = 64,
  parameter int MAX_FRAC_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic [VALUE_W-1:0] in_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_character,
  output logic                   out_last
);

  localparam int WB     = VALUE_BITS - 1;
  localparam int NDIG   = (WB * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * NDIG;
  localparam int FB_W   = $clog2(MAX_FRAC_BITS + 1);
  localparam int CNT_W  = $clog2(WB + 1);
  localparam int NDIG_W = $clog2(NDIG + 1);
  localparam int FRAC_W = MAX_FRAC_BITS;
  localparam int EXT_W  = VALUE_BITS + MAX_FRAC_BITS;

  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [WB-1:0]         bin_r, bin_nxt;
  logic [FRAC_W-1:0]     frac_r, frac_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [NDIG_W-1:0]     ndig_r, ndig_nxt;
  logic [5:0]            prod_r, prod_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic                  valid_r, valid_nxt;

  logic [VALUE_BITS-1:0] v_in;
  logic [FB_W-1:0]       fb_eff;
  logic [5:0]            digs;
  logic [EXT_W-1:0]      ext;
  logic [BCD_W-1:0]      bcd_adj;
  logic [FRAC_W+3:0]     times_ten;
  logic [5:0]            prod_inc;
  logic [3:0]            top_nib;
  logic                  point;
  logic                  frac_final;

  assign v_in = in_value[VALUE_BITS-1:0];

  always_comb begin
    if (cfg.frac_bits == 6'd0) begin
      fb_eff = FB_W'(1);
    end else if (cfg.frac_bits > 6'(MAX_FRAC_BITS)) begin
      fb_eff = FB_W'(MAX_FRAC_BITS);
    end else begin
      fb_eff = FB_W'(cfg.frac_bits);
    end
  end

  assign digs = (cfg.fraction_digits > DIGIT_LIMIT) ? DIGIT_LIMIT : cfg.fraction_digits;

  assign ext = {mag_r, {MAX_FRAC_BITS{1'b0}}} >> fb_eff;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  assign times_ten  = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0};
  assign prod_inc   = prod_r + 6'd1;
  assign top_nib    = bcd_r[BCD_W-1 -: 4];
  assign point      = cfg.minimal_digits ? (frac_r != '0) : (digs != 6'd0);
  assign frac_final = cfg.minimal_digits ?
                      ((times_ten[FRAC_W-1:0] == '0) || (prod_inc == 6'(MAX_FRAC_BITS))) :
                      (prod_inc == digs);

  assign stat.neg         = neg_r;
  assign stat.dabble_done = (cnt_r == CNT_W'(1));
  assign stat.lead_zero   = (top_nib == 4'd0) && (ndig_r != NDIG_W'(1));
  assign stat.int_final   = (ndig_r == NDIG_W'(1));
  assign stat.point       = point;
  assign stat.frac_final  = frac_final;
  assign stat.out_free    = !valid_r || out_ready;

  always_comb begin
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    bin_nxt   = bin_r;
    frac_nxt  = frac_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    prod_nxt  = prod_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    valid_nxt = valid_r && !out_ready;
    if (cmd.load) begin
      neg_nxt = v_in[VALUE_BITS-1];
      mag_nxt = v_in[VALUE_BITS-1] ? (~v_in + 1'b1) : v_in;
    end
    if (cmd.split) begin
      bin_nxt  = ext[EXT_W-2:MAX_FRAC_BITS];
      frac_nxt = ext[MAX_FRAC_BITS-1:0];
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(WB);
      ndig_nxt = NDIG_W'(NDIG);
    end
    if (cmd.dabble) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[WB-1]};
      bin_nxt = {bin_r[WB-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
    if (cmd.skip) begin
      bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
      ndig_nxt = ndig_r - 1'b1;
    end
    if (cmd.emit_sign) begin
      char_nxt  = CHAR_MINUS;
      last_nxt  = 1'b0;
      valid_nxt = 1'b1;
    end
    if (cmd.emit_int) begin
      char_nxt  = CHAR_ZERO + {2'b00, top_nib};
      last_nxt  = (ndig_r == NDIG_W'(1)) && !point;
      valid_nxt = 1'b1;
      bcd_nxt   = {bcd_r[BCD_W-5:0], 4'd0};
      ndig_nxt  = ndig_r - 1'b1;
    end
    if (cmd.emit_point) begin
      char_nxt  = CHAR_POINT;
      last_nxt  = 1'b0;
      valid_nxt = 1'b1;
      prod_nxt  = 6'd0;
    end
    if (cmd.emit_frac) begin
      char_nxt  = CHAR_ZERO + {2'b00, times_ten[FRAC_W+3:FRAC_W]};
      last_nxt  = frac_final;
      valid_nxt = 1'b1;
      frac_nxt  = times_ten[FRAC_W-1:0];
      prod_nxt  = prod_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    bin_r  <= bin_nxt;
    frac_r <= frac_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
    prod_r <= prod_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// ----- src/fpdt_ctrl.sv -----
`default_nettype none

module fpdt_ctrl
  import fpdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SPLIT  = 3'd1;
  localparam logic [2:0] ST_DABBLE = 3'd2;
  localparam logic [2:0] ST_SKIP   = 3'd3;
  localparam logic [2:0] ST_SIGN   = 3'd4;
  localparam logic [2:0] ST_INT    = 3'd5;
  localparam logic [2:0] ST_POINT  = 3'd6;
  localparam logic [2:0] ST_FRAC   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        cmd.split = 1'b1;
        state_nxt = ST_DABBLE;
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
        if (stat.dabble_done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.lead_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = stat.neg ? ST_SIGN : ST_INT;
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_INT;
        end
      end
      ST_INT: begin
        if (stat.out_free) begin
          cmd.emit_int = 1'b1;
          if (stat.int_final) begin
            state_nxt = stat.point ? ST_POINT : ST_IDLE;
          end
        end
      end
      ST_POINT: begin
        if (stat.out_free) begin
          cmd.emit_point = 1'b1;
          state_nxt      = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (stat.out_free) begin
          cmd.emit_frac = 1'b1;
          if (stat.frac_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/fixed_point_to_decimal_text.sv -----
`default_nettype none

// Converts a signed fixed-point value into decimal ASCII text, one character
// per output transaction, with last set on the final character. An input
// transaction is taken only while the converter is idle; a conversion loads
// and splits the value, runs VALUE_BITS-1 shift-and-add-3 binary-to-BCD steps
// on the integer part, skips one leading zero digit per cycle (up to 18 at 64
// bits) plus a step to move on to the output, then emits one character per
// cycle (up to 53) while the receiver keeps up, each fraction digit coming
// from one multiply-by-ten step of the fraction. The output register lets
// the next value be accepted while the final character still waits.
// Configuration is applied as written and should only change while no
// conversion is in flight.
module fixed_point_to_decimal_text
  import fpdt_pkg::*;
#(
  parameter int VALUE_BITS    = 64,
  parameter int MAX_FRAC_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fpdt_cfg_if.sink   cfg_ch,
  fpdt_in_if.sink    in_ch,
  fpdt_out_if.source out_ch
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fpdt_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fpdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fpdt_dp #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_FRAC_BITS (MAX_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last)
  );

endmodule

`default_nettype wire
